// ===== hdl/eihp_pkg.sv =====
// eihp_pkg: types and constants shared by the header parser modules
// holds the captured header state, the result item and the status codes
// no dependencies
package eihp_pkg;

  localparam logic [15:0] TypeVlan = 16'h8100;
  localparam logic [15:0] TypeIpv4 = 16'h0800;
  localparam logic [15:0] TypeIpv6 = 16'h86DD;

  localparam logic [7:0] ProtoTcp = 8'h06;
  localparam logic [7:0] ProtoUdp = 8'h11;

  localparam logic [7:0] EthHdrLen  = 8'd14;
  localparam logic [7:0] VlanHdrLen = 8'd18;
  localparam logic [7:0] HdrMin     = 8'd20;
  localparam logic [7:0] HdrMax     = 8'd60;
  localparam logic [7:0] Ipv6HdrLen = 8'd40;
  localparam logic [7:0] UdpHdrLen  = 8'd8;

  localparam logic [7:0] EthTypeHiPos = 8'd12;
  localparam logic [7:0] EthTypeLoPos = 8'd13;
  localparam logic [7:0] VlanTypeHiPos = 8'd16;
  localparam logic [7:0] VlanTypeLoPos = 8'd17;
  localparam logic [7:0] TcpOffPos    = 8'd12;

  localparam logic [3:0] VerNibble4 = 4'd4;
  localparam logic [3:0] VerNibble6 = 4'd6;

  localparam logic [2:0] IpVerNone = 3'd0;
  localparam logic [2:0] IpVer4    = 3'd4;
  localparam logic [2:0] IpVer6    = 3'd6;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StBadType  = 3'd2,
    StBadVer   = 3'd3,
    StBadIhl   = 3'd4,
    StBadLen   = 3'd5,
    StBadProto = 3'd6,
    StBadTcp   = 3'd7
  } status_e;

  typedef struct packed {
    logic [15:0] eth_type;
    logic        vlan_tagged;
    logic [3:0]  ip_ver_nibble;
    logic [3:0]  ip_hdr_words;
    logic [15:0] ip_length_field;
    logic [7:0]  next_proto;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [7:0]  l4_start;
    logic [3:0]  tcp_hdr_words;
  } hdr_state_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  ip_version;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [7:0]  payload_offset;
  } result_t;

endpackage

// ===== hdl/eihp_capture.sv =====
// eihp_capture: byte counter and header field capture registers
// works out the state after the current byte; clears itself after the last byte
// depends on eihp_pkg
module eihp_capture import eihp_pkg::*; #(
  parameter int COUNT_WIDTH = 17
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  output hdr_state_t             nxt_o,
  output logic [COUNT_WIDTH-1:0] len_o
);

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  hdr_state_t             st_q, st_d;
  logic [COUNT_WIDTH-1:0] pos;
  logic [COUNT_WIDTH-1:0] rel;
  logic [7:0]             l3;
  logic                   is6;

  assign pos   = cnt_q;
  assign cnt_d = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);

  always_comb begin
    st_d = st_q;
    if (pos == COUNT_WIDTH'(EthTypeHiPos)) st_d.eth_type = {byte_i, 8'h00};
    if (pos == COUNT_WIDTH'(EthTypeLoPos)) begin
      st_d.eth_type = {st_q.eth_type[15:8], byte_i};
      if ({st_q.eth_type[15:8], byte_i} == TypeVlan) st_d.vlan_tagged = 1'b1;
    end
    if (st_d.vlan_tagged && pos == COUNT_WIDTH'(VlanTypeHiPos)) begin
      st_d.eth_type = {byte_i, 8'h00};
    end
    if (st_d.vlan_tagged && pos == COUNT_WIDTH'(VlanTypeLoPos)) begin
      st_d.eth_type = {st_q.eth_type[15:8], byte_i};
    end

    l3  = st_d.vlan_tagged ? VlanHdrLen : EthHdrLen;
    is6 = (st_d.eth_type == TypeIpv6);
    rel = pos - COUNT_WIDTH'(l3);

    if (pos >= COUNT_WIDTH'(l3)) begin
      if (rel == '0) begin
        st_d.ip_ver_nibble = byte_i[7:4];
        st_d.ip_hdr_words  = byte_i[3:0];
        st_d.l4_start      = is6 ? l3 + Ipv6HdrLen : l3 + {2'b00, byte_i[3:0], 2'b00};
      end
      if (is6) begin
        if (rel == COUNT_WIDTH'(4)) st_d.ip_length_field = {byte_i, 8'h00};
        if (rel == COUNT_WIDTH'(5)) st_d.ip_length_field = {st_q.ip_length_field[15:8], byte_i};
        if (rel == COUNT_WIDTH'(6)) st_d.next_proto = byte_i;
        // source address bytes 8..15 and 16..23 of the ipv6 header
        if (rel[COUNT_WIDTH-1:3] == (COUNT_WIDTH-3)'(1)) begin
          st_d.src_high = {st_q.src_high[55:0], byte_i};
        end
        if (rel[COUNT_WIDTH-1:3] == (COUNT_WIDTH-3)'(2)) begin
          st_d.src_low = {st_q.src_low[55:0], byte_i};
        end
      end else begin
        if (rel == COUNT_WIDTH'(2)) st_d.ip_length_field = {byte_i, 8'h00};
        if (rel == COUNT_WIDTH'(3)) st_d.ip_length_field = {st_q.ip_length_field[15:8], byte_i};
        if (rel == COUNT_WIDTH'(9)) st_d.next_proto = byte_i;
        // source address bytes 12..15 of the ipv4 header
        if (rel[COUNT_WIDTH-1:2] == (COUNT_WIDTH-2)'(3)) begin
          st_d.src_low = {32'h0, st_q.src_low[23:0], byte_i};
        end
      end
      if (rel != '0 &&
          pos == COUNT_WIDTH'(st_q.l4_start) + COUNT_WIDTH'(TcpOffPos)) begin
        st_d.tcp_hdr_words = byte_i[7:4];
      end
    end
  end

  assign nxt_o = st_d;
  assign len_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      st_q  <= '0;
    end else if (en_i) begin
      if (last_i) begin
        cnt_q <= '0;
        st_q  <= '0;
      end else begin
        cnt_q <= cnt_d;
        st_q  <= st_d;
      end
    end
  end

endmodule

// ===== hdl/eihp_verdict.sv =====
// eihp_verdict: frame checks on the last byte, in fixed priority order
// turns the captured header state and frame length into one result item
// depends on eihp_pkg
module eihp_verdict import eihp_pkg::*; #(
  parameter int COUNT_WIDTH = 17
) (
  input  hdr_state_t             st_i,
  input  logic [COUNT_WIDTH-1:0] len_i,
  output result_t                res_o
);

  logic [COUNT_WIDTH-1:0] off;
  logic [COUNT_WIDTH-1:0] ip_len;
  logic [7:0]             tcp_len;
  logic [7:0]             ihl_len;
  status_e                status;
  logic [2:0]             ver;

  assign ip_len  = COUNT_WIDTH'(st_i.ip_length_field);
  assign tcp_len = {2'b00, st_i.tcp_hdr_words, 2'b00};
  assign ihl_len = {2'b00, st_i.ip_hdr_words, 2'b00};

  always_comb begin
    off    = '0;
    status = StOk;
    ver    = IpVerNone;
    if (len_i < COUNT_WIDTH'(EthHdrLen)) begin
      status = StShort;
    end else if (st_i.vlan_tagged && len_i < COUNT_WIDTH'(VlanHdrLen)) begin
      status = StShort;
      off    = COUNT_WIDTH'(EthHdrLen);
    end else begin
      off = st_i.vlan_tagged ? COUNT_WIDTH'(VlanHdrLen) : COUNT_WIDTH'(EthHdrLen);
      if (st_i.eth_type == TypeIpv4) begin
        if (len_i < off + COUNT_WIDTH'(HdrMin))    status = StShort;
        else if (st_i.ip_ver_nibble != VerNibble4) status = StBadVer;
        else if (ihl_len < HdrMin)                 status = StBadIhl;
        else if (ip_len > len_i)                   status = StBadLen;
        else begin
          ver = IpVer4;
          off = COUNT_WIDTH'(st_i.l4_start);
        end
      end else if (st_i.eth_type == TypeIpv6) begin
        if (len_i < off + COUNT_WIDTH'(Ipv6HdrLen))          status = StShort;
        else if (st_i.ip_ver_nibble != VerNibble6)           status = StBadVer;
        else if (ip_len + COUNT_WIDTH'(Ipv6HdrLen) > len_i)  status = StBadLen;
        else begin
          ver = IpVer6;
          off = COUNT_WIDTH'(st_i.l4_start);
        end
      end else begin
        status = StBadType;
      end
      if (ver != IpVerNone) begin
        if (st_i.next_proto == ProtoTcp) begin
          if (off + COUNT_WIDTH'(HdrMin) > len_i)             status = StShort;
          else if (tcp_len < HdrMin || tcp_len > HdrMax)      status = StBadTcp;
          else if (off + COUNT_WIDTH'(tcp_len) > len_i)       status = StShort;
          else off = off + COUNT_WIDTH'(tcp_len);
        end else if (st_i.next_proto == ProtoUdp) begin
          if (off + COUNT_WIDTH'(UdpHdrLen) > len_i) status = StShort;
          else off = off + COUNT_WIDTH'(UdpHdrLen);
        end else begin
          status = StBadProto;
        end
      end
    end
  end

  assign res_o.status         = status;
  assign res_o.ip_version     = ver;
  assign res_o.src_addr_high  = (ver == IpVer6) ? st_i.src_high : 64'h0;
  assign res_o.src_addr_low   = (ver != IpVerNone) ? st_i.src_low : 64'h0;
  assign res_o.payload_offset = off[7:0];

endmodule

// ===== hdl/eth_ip_l4_header_parser_top.sv =====
// eth_ip_l4_header_parser_top: input register, field capture, checks, result register
// depends on eihp_pkg, eihp_capture, eihp_verdict
//
// Frame header parser for Ethernet with an optional 802.1Q tag, IPv4 or IPv6,
// then TCP or UDP. One frame byte is taken per item, starting at the
// destination MAC, and a byte rate of one item per cycle is sustained while
// the input side is not held. A result item is produced only for the byte
// marked last: status, IP version, source address and the offset of the L4
// payload. It passes the input register, then the result register, and
// input items keep flowing while a result waits; only a last byte that
// finds the result register still occupied holds the input side. IPv6
// extension headers are not followed. The byte counter is COUNT_WIDTH bits
// wide and saturates on long frames. No clearing pass is needed after reset.
module eth_ip_l4_header_parser_top import eihp_pkg::*; #(
  parameter int COUNT_WIDTH = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  ip_version_o,
  output logic [63:0] src_addr_high_o,
  output logic [63:0] src_addr_low_o,
  output logic [7:0]  payload_offset_o
);

  logic                   in_vld_q;
  logic [7:0]             byte_q;
  logic                   last_q;
  logic                   out_vld_q;
  result_t                res_q, res_d;
  hdr_state_t             nxt;
  logic [COUNT_WIDTH-1:0] len;
  logic                   out_free;
  logic                   adv;

  assign out_free   = !out_vld_q || !out_stall_i;
  // a byte that is not last never needs the result register
  assign adv        = in_vld_q && (!last_q || out_free);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  eihp_capture #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .byte_i (byte_q),
    .last_i (last_q),
    .nxt_o  (nxt),
    .len_o  (len)
  );

  eihp_verdict #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_verdict (
    .st_i  (nxt),
    .len_i (len),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = res_q.status;
  assign ip_version_o     = res_q.ip_version;
  assign src_addr_high_o  = res_q.src_addr_high;
  assign src_addr_low_o   = res_q.src_addr_low;
  assign payload_offset_o = res_q.payload_offset;

endmodule
